### design/gf2mqs_pkg.sv
// Shared types and constants for the GF(2^m) quadratic solver.
// No dependencies; used by scoped name by every solver module but gf2mqs_mul_chunk.
package gf2mqs_pkg;

  // Multiplier bits folded into one pipeline stage (Horner steps per stage)
  localparam int CHUNK_BITS = 8;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_SOLVED      = 2'd0,
    STATUS_RETRY       = 2'd1,
    STATUS_NO_SOLUTION = 2'd2
  } status_t;

endpackage

### design/gf2mqs_mul_chunk.sv
// Combinational slice of a shift-and-add GF(2^m) multiplier: N Horner steps.
// Depends on nothing; instantiated by the round and check stages.
module gf2mqs_mul_chunk #(
  parameter int M  = 64,
  parameter int HI = 63,
  parameter int N  = 8
) (
  input  logic [M-1:0] acc_in,
  input  logic [M-1:0] a,
  input  logic [M-1:0] b,
  input  logic [M-1:0] low,
  output logic [M-1:0] acc_out
);

  // acc = acc*x mod P, plus b where the multiplier bit is set, top bit first
  always_comb begin
    logic [M-1:0] r;
    r = acc_in;
    for (int j = 0; j < N; j++) begin
      r = {r[M-2:0], 1'b0} ^ (r[M-1] ? low : '0) ^ (a[HI-j] ? b : '0);
    end
    acc_out = r;
  end

endmodule

### design/gf2mqs_round.sv
// One solver round, z = z^2 + w^2*b and w = w^2 + rho, as 2*NS register stages.
// Depends on gf2mqs_pkg and gf2mqs_mul_chunk.
module gf2mqs_round #(
  parameter int M = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [M-1:0] low,
  input  logic         in_valid,
  input  logic [M-1:0] in_b,
  input  logic [M-1:0] in_rho,
  input  logic [M-1:0] in_z,
  input  logic [M-1:0] in_w,
  output logic         out_valid,
  output logic [M-1:0] out_b,
  output logic [M-1:0] out_rho,
  output logic [M-1:0] out_z,
  output logic [M-1:0] out_w
);

  localparam int CB = gf2mqs_pkg::CHUNK_BITS;
  localparam int NS = (M + CB - 1) / CB;

  // First half: w*w and z*z side by side
  logic [NS-1:0] a_valid;
  logic [M-1:0]  a_b   [NS];
  logic [M-1:0]  a_rho [NS];
  logic [M-1:0]  a_w   [NS];
  logic [M-1:0]  a_z   [NS];
  logic [M-1:0]  a_ww  [NS];
  logic [M-1:0]  a_zz  [NS];

  // Second half: w2*b, with w2 and z^2 carried along
  logic [NS-1:0] m_valid;
  logic [M-1:0]  m_b   [NS];
  logic [M-1:0]  m_rho [NS];
  logic [M-1:0]  m_w2  [NS];
  logic [M-1:0]  m_zz  [NS];
  logic [M-1:0]  m_acc [NS];

  for (genvar k = 0; k < NS; k++) begin : g_sq
    localparam int HI = M - 1 - CB * k;
    localparam int N  = (HI + 1 < CB) ? HI + 1 : CB;

    logic         src_valid;
    logic [M-1:0] src_b, src_rho, src_w, src_z, src_ww, src_zz;
    logic [M-1:0] nxt_ww, nxt_zz;

    if (k == 0) begin : g_first
      assign src_valid = in_valid;
      assign src_b     = in_b;
      assign src_rho   = in_rho;
      assign src_w     = in_w;
      assign src_z     = in_z;
      assign src_ww    = '0;
      assign src_zz    = '0;
    end else begin : g_next
      assign src_valid = a_valid[k-1];
      assign src_b     = a_b[k-1];
      assign src_rho   = a_rho[k-1];
      assign src_w     = a_w[k-1];
      assign src_z     = a_z[k-1];
      assign src_ww    = a_ww[k-1];
      assign src_zz    = a_zz[k-1];
    end

    gf2mqs_mul_chunk #(.M(M), .HI(HI), .N(N)) u_ww (
      .acc_in(src_ww), .a(src_w), .b(src_w), .low(low), .acc_out(nxt_ww)
    );
    gf2mqs_mul_chunk #(.M(M), .HI(HI), .N(N)) u_zz (
      .acc_in(src_zz), .a(src_z), .b(src_z), .low(low), .acc_out(nxt_zz)
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        a_valid[k] <= 1'b0;
      end else if (en) begin
        a_valid[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_b[k]   <= src_b;
        a_rho[k] <= src_rho;
        a_w[k]   <= src_w;
        a_z[k]   <= src_z;
        a_ww[k]  <= nxt_ww;
        a_zz[k]  <= nxt_zz;
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_mb
    localparam int HI = M - 1 - CB * k;
    localparam int N  = (HI + 1 < CB) ? HI + 1 : CB;

    logic         src_valid;
    logic [M-1:0] src_b, src_rho, src_w2, src_zz, src_acc;
    logic [M-1:0] nxt_acc;

    if (k == 0) begin : g_first
      assign src_valid = a_valid[NS-1];
      assign src_b     = a_b[NS-1];
      assign src_rho   = a_rho[NS-1];
      assign src_w2    = a_ww[NS-1];
      assign src_zz    = a_zz[NS-1];
      assign src_acc   = '0;
    end else begin : g_next
      assign src_valid = m_valid[k-1];
      assign src_b     = m_b[k-1];
      assign src_rho   = m_rho[k-1];
      assign src_w2    = m_w2[k-1];
      assign src_zz    = m_zz[k-1];
      assign src_acc   = m_acc[k-1];
    end

    gf2mqs_mul_chunk #(.M(M), .HI(HI), .N(N)) u_wb (
      .acc_in(src_acc), .a(src_w2), .b(src_b), .low(low), .acc_out(nxt_acc)
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        m_valid[k] <= 1'b0;
      end else if (en) begin
        m_valid[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_b[k]   <= src_b;
        m_rho[k] <= src_rho;
        m_w2[k]  <= src_w2;
        m_zz[k]  <= src_zz;
        m_acc[k] <= nxt_acc;
      end
    end
  end

  // Round update from the last stage
  assign out_valid = m_valid[NS-1];
  assign out_b     = m_b[NS-1];
  assign out_rho   = m_rho[NS-1];
  assign out_z     = m_zz[NS-1] ^ m_acc[NS-1];
  assign out_w     = m_w2[NS-1] ^ m_rho[NS-1];

endmodule

### design/gf2mqs_check.sv
// Final check stages: z^2 + z against b, w against zero, and status encoding.
// Depends on gf2mqs_pkg and gf2mqs_mul_chunk.
module gf2mqs_check #(
  parameter int M = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [M-1:0]        low,
  input  logic                in_valid,
  input  logic [M-1:0]        in_b,
  input  logic [M-1:0]        in_z,
  input  logic [M-1:0]        in_w,
  output logic                out_valid,
  output logic [M-1:0]        out_z,
  output gf2mqs_pkg::status_t out_status
);

  localparam int CB = gf2mqs_pkg::CHUNK_BITS;
  localparam int NS = (M + CB - 1) / CB;

  logic [NS-1:0] c_valid;
  logic [M-1:0]  c_b   [NS];
  logic [M-1:0]  c_z   [NS];
  logic [M-1:0]  c_w   [NS];
  logic [M-1:0]  c_zz  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_st
    localparam int HI = M - 1 - CB * k;
    localparam int N  = (HI + 1 < CB) ? HI + 1 : CB;

    logic         src_valid;
    logic [M-1:0] src_b, src_z, src_w, src_zz;
    logic [M-1:0] nxt_zz;

    if (k == 0) begin : g_first
      assign src_valid = in_valid;
      assign src_b     = in_b;
      assign src_z     = in_z;
      assign src_w     = in_w;
      assign src_zz    = '0;
    end else begin : g_next
      assign src_valid = c_valid[k-1];
      assign src_b     = c_b[k-1];
      assign src_z     = c_z[k-1];
      assign src_w     = c_w[k-1];
      assign src_zz    = c_zz[k-1];
    end

    gf2mqs_mul_chunk #(.M(M), .HI(HI), .N(N)) u_zz (
      .acc_in(src_zz), .a(src_z), .b(src_z), .low(low), .acc_out(nxt_zz)
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        c_valid[k] <= 1'b0;
      end else if (en) begin
        c_valid[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_b[k]  <= src_b;
        c_z[k]  <= src_z;
        c_w[k]  <= src_w;
        c_zz[k] <= nxt_zz;
      end
    end
  end

  // Retry takes priority over the root check; z reads zero unless solved
  always_comb begin
    if (c_w[NS-1] == '0) begin
      out_status = gf2mqs_pkg::STATUS_RETRY;
    end else if ((c_zz[NS-1] ^ c_z[NS-1]) != c_b[NS-1]) begin
      out_status = gf2mqs_pkg::STATUS_NO_SOLUTION;
    end else begin
      out_status = gf2mqs_pkg::STATUS_SOLVED;
    end
  end

  assign out_valid = c_valid[NS-1];
  assign out_z     = (out_status == gf2mqs_pkg::STATUS_SOLVED) ? c_z[NS-1] : '0;

endmodule

### design/gf2m_quadratic_solver_core.sv
// Top level of the GF(2^m) quadratic solver: round pipeline, check and output skid.
// Depends on gf2mqs_pkg, gf2mqs_round and gf2mqs_check.
//
// Solves z^2 + z = b over GF(2^M), field polynomial x^M + reduction_poly_low
// (register written through cfg_we/cfg_wdata, reset value 27; the user must write
// it only while idle, the block does not enforce it). Each request carries b and a
// random rho; the block runs M-1 rounds of z = z^2 + w^2*b, w = w^2 + rho from
// z = 0, w = rho and returns z with status 0 (solved), 1 (w ended at zero: resend
// with a new rho) or 2 (no solution, z = 0). A new request is taken every cycle
// while the skid stage is empty. Every GF multiply is split into ceil(M/8) 8-bit
// Horner slices, one pipeline stage each: two chained multiplies per round, one for
// the final check, plus one output register. A two-entry output register and skid
// stage hold results; the whole pipe holds only while the skid is full.
module gf2m_quadratic_solver_core #(
  parameter int M = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [63:0]  cfg_wdata,       // reduction_poly_low
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,    // [63:0] b_value, [127:64] rho_value
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata     // [63:0] z_value, [65:64] status, rest zero
);

  // Field polynomial register
  logic [63:0] poly;
  logic [M-1:0] low;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly <= 64'd27;
    end else if (cfg_we) begin
      poly <= cfg_wdata;
    end
  end

  assign low = poly[M-1:0];

  // Global pipe advance
  logic en;
  logic k_valid;

  assign en            = !k_valid;
  assign s_axis_tready = en;

  // Round chain: ch[0] is the request, ch[r+1] the result of round r
  logic [M-1:0] ch_valid;
  logic [M-1:0] ch_b   [M];
  logic [M-1:0] ch_rho [M];
  logic [M-1:0] ch_z   [M];
  logic [M-1:0] ch_w   [M];

  assign ch_valid[0] = s_axis_tvalid;
  assign ch_b[0]     = s_axis_tdata[M-1:0];
  assign ch_rho[0]   = s_axis_tdata[64+M-1:64];
  assign ch_z[0]     = '0;
  assign ch_w[0]     = s_axis_tdata[64+M-1:64];

  for (genvar r = 0; r < M - 1; r++) begin : g_round
    gf2mqs_round #(.M(M)) u_round (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .low       (low),
      .in_valid  (ch_valid[r]),
      .in_b      (ch_b[r]),
      .in_rho    (ch_rho[r]),
      .in_z      (ch_z[r]),
      .in_w      (ch_w[r]),
      .out_valid (ch_valid[r+1]),
      .out_b     (ch_b[r+1]),
      .out_rho   (ch_rho[r+1]),
      .out_z     (ch_z[r+1]),
      .out_w     (ch_w[r+1])
    );
  end

  // Root check and status
  logic                res_valid;
  logic [M-1:0]        res_z;
  gf2mqs_pkg::status_t res_status;

  gf2mqs_check #(.M(M)) u_check (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .low        (low),
    .in_valid   (ch_valid[M-1]),
    .in_b       (ch_b[M-1]),
    .in_z       (ch_z[M-1]),
    .in_w       (ch_w[M-1]),
    .out_valid  (res_valid),
    .out_z      (res_z),
    .out_status (res_status)
  );

  // Output register with skid stage behind it
  logic                o_valid;
  logic [M-1:0]        o_z;
  gf2mqs_pkg::status_t o_status;
  logic [M-1:0]        k_z;
  gf2mqs_pkg::status_t k_status;
  logic                pop;

  assign pop = o_valid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      k_valid <= 1'b0;
    end else if (k_valid) begin
      if (pop) begin
        o_valid  <= 1'b1;
        o_z      <= k_z;
        o_status <= k_status;
        k_valid  <= 1'b0;
      end
    end else if (!o_valid || pop) begin
      o_valid  <= res_valid;
      o_z      <= res_z;
      o_status <= res_status;
    end else if (res_valid) begin
      k_valid  <= 1'b1;
      k_z      <= res_z;
      k_status <= res_status;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {6'd0, o_status, {(64-M){1'b0}}, o_z};

  // Skid fills only when the output register is held
  a_skid_fill : assert property (@(posedge clk) disable iff (rst)
    $rose(k_valid) |-> $past(o_valid && !m_axis_tready))
    else $error("skid filled while output was free");

  // Skid never holds data ahead of the output register
  a_skid_order : assert property (@(posedge clk) disable iff (rst)
    k_valid |-> o_valid)
    else $error("skid valid without output valid");

  // Unsolved results carry z = 0
  a_zero_z : assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_status != gf2mqs_pkg::STATUS_SOLVED) |-> (o_z == '0))
    else $error("nonzero z on unsolved result");

endmodule

### test/gf2mqs_checker.sv
`timescale 1ns / 100ps
// Checker for the GF(2^m) quadratic solver: watches the config and stream ports,
// predicts each result and compares it with what comes out. Depends on gf2mqs_pkg.
module gf2mqs_checker #(
  parameter int M = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [63:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,    // [63:0] b_value, [127:64] rho_value
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [71:0]  m_axis_tdata,    // [63:0] z_value, [65:64] status, rest zero
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [63:0]          z;
    gf2mqs_pkg::status_t  status;
  } root_t;

  // Roots predicted for accepted requests, oldest first
  root_t       root_q[$];
  logic [63:0] poly_low;

  // Horner multiply mod x^M + low
  function automatic logic [63:0] field_mul(input logic [63:0] a, input logic [63:0] c,
                                            input logic [63:0] low);
    logic [63:0] mask;
    logic [63:0] r;
    mask = {64{1'b1}} >> (64 - M);
    r = '0;
    for (int i = M - 1; i >= 0; i--) begin
      r = r[M-1] ? (((r << 1) & mask) ^ low) : ((r << 1) & mask);
      if (a[i]) r = r ^ c;
    end
    return r & mask;
  endfunction

  // Trace-style iteration for z^2 + z = b, then the retry and root checks
  function automatic root_t solve_quadratic(input logic [63:0] b_in, input logic [63:0] rho_in,
                                            input logic [63:0] poly);
    logic [63:0] mask;
    logic [63:0] low;
    logic [63:0] b;
    logic [63:0] rho;
    logic [63:0] z;
    logic [63:0] w;
    logic [63:0] w2;
    root_t       res;
    mask = {64{1'b1}} >> (64 - M);
    low = poly & mask;
    b = b_in & mask;
    rho = rho_in & mask;
    z = '0;
    w = rho;
    for (int i = 1; i < M; i++) begin
      w2 = field_mul(w, w, low);
      z = field_mul(z, z, low) ^ field_mul(w2, b, low);
      w = w2 ^ rho;
    end
    if (w == '0) begin
      res.z = '0;
      res.status = gf2mqs_pkg::STATUS_RETRY;
    end else if ((field_mul(z, z, low) ^ z) != b) begin
      res.z = '0;
      res.status = gf2mqs_pkg::STATUS_NO_SOLUTION;
    end else begin
      res.z = z & mask;
      res.status = gf2mqs_pkg::STATUS_SOLVED;
    end
    return res;
  endfunction

  // Track config, queue predictions, compare results
  always @(posedge clk) begin : watch
    root_t want;
    logic  bad;
    if (rst) begin
      poly_low <= 64'd27;
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) poly_low <= cfg_wdata;
      if (s_axis_tvalid && s_axis_tready)
        root_q.push_back(solve_quadratic(s_axis_tdata[63:0], s_axis_tdata[127:64], poly_low));
      if (m_axis_tvalid && m_axis_tready) begin
        if (root_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: z=%h status=%0d", m_axis_tdata[63:0],
                     m_axis_tdata[65:64]);
          fail_count <= fail_count + 1;
        end else begin
          want = root_q.pop_front();
          bad = (m_axis_tdata[63:0] !== want.z) || (m_axis_tdata[65:64] !== want.status) ||
                (m_axis_tdata[71:66] !== 6'd0);
          if (bad) begin
            if (fail_count < 10)
              $display("mismatch: expected z=%h status=%0d, got z=%h status=%0d pad=%h",
                       want.z, want.status, m_axis_tdata[63:0], m_axis_tdata[65:64],
                       m_axis_tdata[71:66]);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= root_q.size();
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// Testbench top for gf2m_quadratic_solver_core: clock, reset, request stimulus,
// result backpressure and verdict. Depends on gf2mqs_checker and the solver RTL.
module tb;

  localparam int M           = 64;
  localparam int LATENCY     = 1017;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 2500;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [63:0]  cfg_wdata;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;    // [63:0] b_value, [127:64] rho_value
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [71:0]  m_axis_tdata;    // [63:0] z_value, [65:64] status, rest zero
  int           fail_count;
  int           pending;
  int           quiet_cycles;
  logic [63:0]  poly_now;
  bit           hold_req;
  bit           hold_done;
  bit           tx_idle_en;
  bit           rx_idle_en;

  gf2m_quadratic_solver_core #(.M(M)) uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  gf2mqs_checker #(.M(M)) chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: cycles with no request or result accepted
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    hold_done = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // Stimulus-side multiply, used to build b values that have a root
  function automatic logic [63:0] poly_mul(input logic [63:0] a, input logic [63:0] c,
                                           input logic [63:0] low);
    logic [63:0] mask;
    logic [63:0] r;
    mask = {64{1'b1}} >> (64 - M);
    r = '0;
    for (int i = M - 1; i >= 0; i--) begin
      r = r[M-1] ? (((r << 1) & mask) ^ (low & mask)) : ((r << 1) & mask);
      if (a[i]) r = r ^ c;
    end
    return r & mask;
  endfunction

  function automatic logic [63:0] rand_elem();
    return {$urandom, $urandom};
  endfunction

  // b = z^2 + z for a random z, so a root exists in a field
  function automatic logic [63:0] solvable_b();
    logic [63:0] z;
    z = rand_elem();
    return poly_mul(z, z, poly_now) ^ z;
  endfunction

  function automatic logic [63:0] edge_elem();
    case ($urandom_range(0, 3))
      0: return 64'd0;
      1: return 64'd1;
      2: return {64{1'b1}};
      default: return 64'h8000_0000_0000_0000;
    endcase
  endfunction

  task automatic send_req(input logic [63:0] b, input logic [63:0] rho);
    s_axis_tdata <= {rho, b};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic sender_gap();
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every predicted result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_poly(input logic [63:0] value);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    poly_now = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly solvable b, plus random b and corner values of both fields
  task automatic random_reqs(input int count);
    logic [63:0] b;
    logic [63:0] rho;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin b = solvable_b(); rho = rand_elem(); end
        6: begin b = rand_elem(); rho = rand_elem(); end
        7: begin b = solvable_b(); rho = edge_elem(); end
        8: begin b = edge_elem(); rho = rand_elem(); end
        default: begin b = rand_elem(); rho = edge_elem(); end
      endcase
      send_req(b, rho);
      sender_gap();
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    poly_now = 64'd27;
    hold_req = 1'b0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests on the reset polynomial
    send_req(64'd0, 64'd1);
    send_req(64'd0, 64'd0);
    send_req({64{1'b1}}, {64{1'b1}});
    send_req(64'd1, 64'd2);
    send_req(64'd1, 64'd1);
    send_req(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_req(64'd27, 64'd27);
    send_req(rand_elem(), {64{1'b1}});
    send_req(rand_elem(), 64'd0);
    for (int k = 0; k < 8; k++) send_req(solvable_b(), rand_elem());
    send_req(rand_elem(), rand_elem());
    send_req(rand_elem(), rand_elem());
    drain();

    // Main run; receiver holds off long enough to back up the pipe
    write_poly(64'd27);
    hold_req = 1'b1;
    random_reqs(1300);
    drain();

    // Extremes and a random value; the reducible rings included
    write_poly(64'd0);
    random_reqs(120);
    drain();
    write_poly({64{1'b1}});
    random_reqs(120);
    drain();
    write_poly(rand_elem());
    random_reqs(120);
    drain();

    // Last part at full rate on both sides
    write_poly(64'd27);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    random_reqs(240);
    drain();
    repeat (LATENCY + 20) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### files.f
design/gf2mqs_pkg.sv
design/gf2mqs_mul_chunk.sv
design/gf2mqs_round.sv
design/gf2mqs_check.sv
design/gf2m_quadratic_solver_core.sv
test/gf2mqs_checker.sv
test/tb.sv
